FILE: sv/gtlw_pkg.sv
`default_nettype none

package gtlw_pkg;

    localparam int MAX_LINE    = 48;
    localparam int STORE_DEPTH = MAX_LINE + 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LIMIT_W     = $clog2(MAX_LINE + 2);

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    // font size codes with a divisor of their own
    localparam logic [7:0] FONT_SMALL = 8'd10;
    localparam logic [7:0] FONT_MID   = 8'd20;
    localparam logic [7:0] FONT_BIG   = 8'd30;

    // configuration register indexes
    localparam logic REG_BOX_WIDTH = 1'b0;
    localparam logic REG_FONT_SIZE = 1'b1;

    localparam logic [11:0] BOX_WIDTH_RESET = 12'd400;
    localparam logic [7:0]  FONT_SIZE_RESET = 8'd10;

    // x / 5 = (x * 1639) >> 13, exact for x below 2048
    localparam logic [10:0] RECIP_FIVE = 11'd1639;
    localparam int          RECIP_SHIFT = 13;

    // Line limit: box / 10, 20, 16 or 40, saturated at MAX_LINE.
    // Divisors 10, 20 and 40 are a shift followed by a divide by five.
    function automatic logic [LIMIT_W-1:0] calc_limit(input logic [11:0] box,
                                                     input logic [7:0]  font);
        logic [10:0] y;
        logic [21:0] prod;
        logic [11:0] q;
        case (font)
            FONT_SMALL: y = box[11:1];
            FONT_MID:   y = {1'b0, box[11:2]};
            default:    y = {2'b0, box[11:3]};
        endcase
        prod = 22'(y) * 22'(RECIP_FIVE);
        q = 12'(prod >> RECIP_SHIFT);
        if (font == FONT_BIG)
        begin
            q = {4'b0, box[11:4]};
        end
        if (q > 12'(MAX_LINE))
        begin
            calc_limit = LIMIT_W'(MAX_LINE);
        end
        else
        begin
            calc_limit = q[LIMIT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/gtlw_ram.sv
`default_nettype none

module gtlw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 49
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/greedy_text_line_wrapper.sv
`default_nettype none

// Channel   | direction | handshake        | content
// s_*       | in        | tvalid / tready  | tdata = text byte, tlast = end of text
// m_*       | out       | tvalid / tready  | tdata = wrapped byte, tlast = last word of
//           |           |                  | the input, tuser = last word of the string
// cfg_*     | in        | valid / ready    | index 0 box width, index 1 font size
//
// An input passes through accept, one step and finish, and through a break as well when a break follows
// a counted character. Releasing a held word reads and sends each of its characters, sends each break
// inside it and ends with a closing check; the end of the string releases it from the finish step.
// A one-word holding stage keeps the last word back until the item is finished, so that its
// tlast can be set; a sink that holds off stalls any cycle that sends a word.
// Reset (rst_n low, asynchronous) clears all control state; the store needs none.

module greedy_text_line_wrapper (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [7:0] wrapped_byte
    output logic             m_tlast,   // run_last
    output logic             m_tuser,   // [0] text_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [11:0] cfg_data
);

    localparam int AW = gtlw_pkg::ADDR_W;
    localparam int LW = gtlw_pkg::LIMIT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NORMAL,
        ST_BREAK,
        ST_FLUSH_RD,
        ST_FLUSH_CH,
        ST_FLUSH_NL,
        ST_END
    } state_t;

    state_t      state_reg, state_next;
    logic [11:0] box_reg, box_next;
    logic [7:0]  font_reg, font_next;
    logic [7:0]  b_reg, b_next;
    logic        eot_reg, eot_next;
    logic        in_text_reg, in_text_next;
    logic [LW-1:0] limit_reg, limit_next;
    logic [LW-1:0] cl_reg, cl_next;
    logic        sp_reg, sp_next;
    logic [AW-1:0] wc_reg, wc_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic        after_normal_reg, after_normal_next;
    logic        hold_valid_reg, hold_valid_next;
    logic [7:0]  hold_byte_reg, hold_byte_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic        out_done_reg, out_done_next;

    logic        out_free;
    logic        can_emit;
    logic        emit_req;
    logic [7:0]  emit_byte;
    logic        fin_go;
    logic        ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic        ram_rd_en;
    logic [7:0]  ram_rd_data;
    logic        sp_eff;
    logic [AW-1:0] wc_eff;
    logic        is_sep;
    logic [LW-1:0] cl_inc;
    logic [AW:0] word_span;

    gtlw_ram #(
        .WIDTH(8),
        .DEPTH(gtlw_pkg::STORE_DEPTH)
    ) u_word_store (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(b_next),
        .rd_en  (ram_rd_en),
        .rd_addr(idx_reg),
        .rd_data(ram_rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_byte_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_done_reg;

    assign out_free  = !out_valid_reg || m_tready;
    assign can_emit  = !hold_valid_reg || out_free;
    assign sp_eff    = in_text_reg && sp_reg;
    assign wc_eff    = in_text_reg ? wc_reg : '0;
    assign is_sep    = (s_tdata == gtlw_pkg::CH_SPACE) || (s_tdata == gtlw_pkg::CH_NEWLINE);
    assign cl_inc    = cl_reg + LW'(1);
    assign word_span = (AW+1)'(wc_reg) + (AW+1)'(cl_reg);

    always_comb
    begin
        state_next        = state_reg;
        box_next          = box_reg;
        font_next         = font_reg;
        b_next            = b_reg;
        eot_next          = eot_reg;
        in_text_next      = in_text_reg;
        limit_next        = limit_reg;
        cl_next           = cl_reg;
        sp_next           = sp_reg;
        wc_next           = wc_reg;
        idx_next          = idx_reg;
        after_normal_next = after_normal_reg;
        hold_valid_next   = hold_valid_reg;
        hold_byte_next    = hold_byte_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_byte_next     = out_byte_reg;
        out_last_next     = out_last_reg;
        out_done_next     = out_done_reg;
        emit_req          = 1'b0;
        emit_byte         = gtlw_pkg::CH_NEWLINE;
        fin_go            = 1'b0;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = wc_eff;
        ram_rd_en         = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                gtlw_pkg::REG_BOX_WIDTH: box_next = cfg_data;
                gtlw_pkg::REG_FONT_SIZE: font_next = cfg_data[7:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    b_next       = s_tdata;
                    eot_next     = s_tlast;
                    in_text_next = 1'b1;
                    if (!in_text_reg)
                    begin
                        limit_next = gtlw_pkg::calc_limit(box_reg, font_reg);
                        cl_next    = '0;
                        sp_next    = 1'b0;
                        wc_next    = '0;
                    end
                    if (sp_eff && !is_sep)
                    begin
                        // hold the character in the word store while it has room
                        if (wc_eff < AW'(gtlw_pkg::STORE_DEPTH))
                        begin
                            ram_wr_en = 1'b1;
                            wc_next   = wc_eff + AW'(1);
                        end
                        state_next = ST_CHECK;
                    end
                    else if (sp_eff)
                    begin
                        idx_next          = '0;
                        after_normal_next = 1'b1;
                        state_next        = ST_FLUSH_RD;
                    end
                    else
                    begin
                        state_next = ST_NORMAL;
                    end
                end
            end

            ST_CHECK:
            begin
                if (word_span > (AW+1)'(limit_reg))
                begin
                    // word no longer fits: break, then release it
                    emit_req = 1'b1;
                    if (can_emit)
                    begin
                        cl_next           = '0;
                        idx_next          = '0;
                        after_normal_next = 1'b0;
                        state_next        = ST_FLUSH_RD;
                    end
                end
                else
                begin
                    state_next = ST_END;
                end
            end

            ST_FLUSH_RD:
            begin
                if (idx_reg == wc_reg)
                begin
                    wc_next    = '0;
                    sp_next    = 1'b0;
                    state_next = after_normal_reg ? ST_NORMAL : ST_END;
                end
                else
                begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_FLUSH_CH;
                end
            end

            ST_FLUSH_CH:
            begin
                emit_req  = 1'b1;
                emit_byte = ram_rd_data;
                if (can_emit)
                begin
                    cl_next = cl_inc;
                    if (cl_inc > limit_reg)
                    begin
                        state_next = ST_FLUSH_NL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_FLUSH_RD;
                    end
                end
            end

            ST_FLUSH_NL:
            begin
                emit_req = 1'b1;
                if (can_emit)
                begin
                    cl_next    = '0;
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_FLUSH_RD;
                end
            end

            ST_NORMAL:
            begin
                emit_req  = 1'b1;
                emit_byte = b_reg;
                if (can_emit)
                begin
                    if (b_reg == gtlw_pkg::CH_NEWLINE)
                    begin
                        cl_next    = '0;
                        state_next = ST_END;
                    end
                    else if (b_reg == gtlw_pkg::CH_SPACE)
                    begin
                        sp_next    = 1'b1;
                        wc_next    = '0;
                        state_next = (cl_reg > limit_reg) ? ST_BREAK : ST_END;
                    end
                    else
                    begin
                        cl_next    = cl_inc;
                        state_next = (cl_inc > limit_reg) ? ST_BREAK : ST_END;
                    end
                end
            end

            ST_BREAK:
            begin
                emit_req = 1'b1;
                if (can_emit)
                begin
                    cl_next    = '0;
                    state_next = ST_END;
                end
            end

            ST_END:
            begin
                if (eot_reg && sp_reg)
                begin
                    // end of string releases the held word without a break
                    idx_next          = '0;
                    after_normal_next = 1'b0;
                    state_next        = ST_FLUSH_RD;
                end
                else if (!hold_valid_reg || out_free)
                begin
                    fin_go = hold_valid_reg;
                    if (eot_reg)
                    begin
                        in_text_next = 1'b0;
                        cl_next      = '0;
                        sp_next      = 1'b0;
                        wc_next      = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // advance the holding stage into the output register
        if (emit_req && can_emit)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = hold_byte_reg;
                out_last_next  = 1'b0;
                out_done_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_byte_next  = emit_byte;
        end

        if (fin_go)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = hold_byte_reg;
            out_last_next   = 1'b1;
            out_done_next   = eot_reg;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            box_reg          <= gtlw_pkg::BOX_WIDTH_RESET;
            font_reg         <= gtlw_pkg::FONT_SIZE_RESET;
            b_reg            <= '0;
            eot_reg          <= 1'b0;
            in_text_reg      <= 1'b0;
            limit_reg        <= '0;
            cl_reg           <= '0;
            sp_reg           <= 1'b0;
            wc_reg           <= '0;
            idx_reg          <= '0;
            after_normal_reg <= 1'b0;
            hold_valid_reg   <= 1'b0;
            hold_byte_reg    <= '0;
            out_valid_reg    <= 1'b0;
            out_byte_reg     <= '0;
            out_last_reg     <= 1'b0;
            out_done_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            box_reg          <= box_next;
            font_reg         <= font_next;
            b_reg            <= b_next;
            eot_reg          <= eot_next;
            in_text_reg      <= in_text_next;
            limit_reg        <= limit_next;
            cl_reg           <= cl_next;
            sp_reg           <= sp_next;
            wc_reg           <= wc_next;
            idx_reg          <= idx_next;
            after_normal_reg <= after_normal_next;
            hold_valid_reg   <= hold_valid_next;
            hold_byte_reg    <= hold_byte_next;
            out_valid_reg    <= out_valid_next;
            out_byte_reg     <= out_byte_next;
            out_last_reg     <= out_last_next;
            out_done_reg     <= out_done_next;
        end
    end

endmodule

`default_nettype wire
